[hdl/sbus_frame_decoder_macros.svh]
// Assertion macros for the serial frame decoder.
// Each macro expects signals named clk and rst in the including scope.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define SBUS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define SBUS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sbus_pkg.sv]
// Shared types and constants for the serial frame decoder.
// No dependencies; imported by every module of the block.
package sbus_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int CHANNEL_BITS = 11;
  localparam int CHANNELS     = 16;
  localparam int ADDR_W       = 5;
  localparam int CH_W         = 4;
  localparam int VAL_W        = 16;
  localparam int PROD_W       = CHANNEL_BITS + VAL_W;
  localparam int STEP_W       = 5;

  localparam logic [ADDR_W-1:0] START_ADDR = 5'd0;
  localparam logic [ADDR_W-1:0] FLAG_ADDR  = 5'd23;
  localparam logic [ADDR_W-1:0] END_ADDR   = 5'd24;
  localparam logic [ADDR_W-1:0] LAST_COUNT = 5'd25;
  localparam logic [CH_W-1:0]   LAST_CH    = 4'd15;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FRAME = 2'd1;
  localparam logic [1:0] ERR_FLAGS = 2'd2;
  localparam logic [1:0] ERR_RANGE = 2'd3;

  localparam logic [2:0] CFG_SANITY_MIN = 3'd0;
  localparam logic [2:0] CFG_SANITY_MAX = 3'd1;
  localparam logic [2:0] CFG_CLIP_MIN   = 3'd2;
  localparam logic [2:0] CFG_CLIP_MAX   = 3'd3;
  localparam logic [2:0] CFG_SCALE_MUL  = 3'd4;
  localparam logic [2:0] CFG_SCALE_DIV  = 3'd5;
  localparam logic [2:0] CFG_FS_ANALOG  = 3'd6;
  localparam logic [2:0] CFG_FS_DIGITAL = 3'd7;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] sanity_min;
    logic [CHANNEL_BITS-1:0] sanity_max;
    logic [CHANNEL_BITS-1:0] clip_min;
    logic [CHANNEL_BITS-1:0] clip_max;
    logic [VAL_W-1:0]        scale_mul;
    logic [VAL_W-1:0]        scale_div;
    logic [VAL_W-1:0]        failsafe_analog;
    logic                    failsafe_digital;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR0,
    S_HDR1,
    S_HDR2,
    S_HDR3,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_CLAMP,
    S_MUL,
    S_DGO,
    S_DWAIT,
    S_EMIT
  } state_t;

endpackage

[hdl/sbus_store.sv]
// Frame byte store: 25 x 8 synchronous memory, one write and one read port.
// Read data is registered. Depends on sbus_pkg.
module sbus_store
  import sbus_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/sbus_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sbus_pkg.
module sbus_div
  import sbus_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [VAL_W-1:0]  divisor,
  output logic              busy,
  output logic [PROD_W-1:0] quotient
);

  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] dvd;
  logic [VAL_W-1:0]  dvs;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, dvd[PROD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(PROD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[PROD_W-2:0], 1'b0};
      rem      <= fits ? VAL_W'(trial - {1'b0, dvs}) : trial[VAL_W-1:0];
      quotient <= {quotient[PROD_W-2:0], fits};
    end
  end

endmodule

[hdl/sbus_ctrl.sv]
// Decode sequencer: reads the stored frame, checks it, scales each channel
// or substitutes failsafe values, and drives the result register. Depends on sbus_pkg and sbus_div.
module sbus_ctrl
  import sbus_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              go,
  output logic              busy,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CH_W-1:0]   channel_index,
  output logic [VAL_W-1:0]  channel_value,
  output logic              digital_17,
  output logic              digital_18,
  output logic              frame_lost,
  output logic              failsafe_active,
  output logic [1:0]        error_code,
  output logic              last_of_frame
);

  state_t state, state_next;

  logic [CH_W-1:0]         ch;
  logic                    pass;       // 0: window check, 1: scaling
  logic                    range_err;
  logic                    start_ok;
  logic                    end_ok;
  logic [3:0]              flag_bits;
  logic [1:0]              err;
  logic                    use_def;
  logic [7:0]              b0, b1;
  logic [CHANNEL_BITS-1:0] raw_q;
  logic [CHANNEL_BITS-1:0] off;
  logic [PROD_W-1:0]       prod;

  logic [7:0]              pos;
  logic [ADDR_W-1:0]       idx;
  logic [23:0]             window;
  logic [CHANNEL_BITS-1:0] raw;
  logic                    raw_bad;
  logic                    hdr_def;
  logic [CHANNEL_BITS-1:0] lo_clamp, hi_clamp;
  logic                    out_free;
  logic                    div_start;
  logic                    div_busy;
  logic [PROD_W-1:0]       quotient;

  sbus_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (cfg.scale_div),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // channel bit position = ch * 11, byte 1 onwards
  always_comb begin
    pos     = {1'b0, ch, 3'b000} + {3'b000, ch, 1'b0} + {4'b0000, ch};
    idx     = ADDR_W'(1) + pos[7:3];
    window  = {rd_data, b1, b0} >> pos[2:0];
    raw     = window[CHANNEL_BITS-1:0];
    raw_bad = (raw < cfg.sanity_min) || (raw > cfg.sanity_max);
    hdr_def = !(start_ok && end_ok) || (rd_data[7:4] != 4'h0) || rd_data[3];
    lo_clamp = (raw_q < cfg.clip_min) ? cfg.clip_min : raw_q;
    hi_clamp = (lo_clamp > cfg.clip_max) ? cfg.clip_max : lo_clamp;
    out_free = !out_valid || !out_stall;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (go) state_next = S_HDR0;
      S_HDR0:  state_next = S_HDR1;
      S_HDR1:  state_next = S_HDR2;
      S_HDR2:  state_next = S_HDR3;
      S_HDR3:  state_next = hdr_def ? S_EMIT : S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3: begin
        if (pass) begin
          state_next = S_CLAMP;
        end else if (ch == LAST_CH) begin
          state_next = (range_err || raw_bad) ? S_EMIT : S_RD0;
        end else begin
          state_next = S_RD0;
        end
      end
      S_CLAMP: state_next = S_MUL;
      S_MUL:   state_next = S_DGO;
      S_DGO:   state_next = S_DWAIT;
      S_DWAIT: if (!div_busy) state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (ch == LAST_CH) begin
            state_next = S_IDLE;
          end else if (!use_def) begin
            state_next = S_RD0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_addr   = START_ADDR;
    div_start = 1'b0;
    busy      = (state != S_IDLE);
    unique case (state)
      S_HDR1:  rd_addr = END_ADDR;
      S_HDR2:  rd_addr = FLAG_ADDR;
      S_RD0:   rd_addr = idx;
      S_RD1:   rd_addr = idx + ADDR_W'(1);
      S_RD2:   rd_addr = idx + ADDR_W'(2);
      S_DGO:   div_start = 1'b1;
      default: rd_addr = START_ADDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_HDR1: start_ok <= (rd_data == START_BYTE);
      S_HDR2: end_ok   <= (rd_data == END_BYTE);
      S_HDR3: begin
        flag_bits <= rd_data[3:0];
        ch        <= '0;
        pass      <= 1'b0;
        range_err <= 1'b0;
        use_def   <= hdr_def;
        if (!(start_ok && end_ok)) begin
          err <= ERR_FRAME;
        end else if (rd_data[7:4] != 4'h0) begin
          err <= ERR_FLAGS;
        end else begin
          err <= ERR_NONE;
        end
      end
      S_RD1: b0 <= rd_data;
      S_RD2: b1 <= rd_data;
      S_RD3: begin
        raw_q <= raw;
        if (!pass) begin
          range_err <= range_err || raw_bad;
          ch        <= ch + 1'b1;
          if (ch == LAST_CH) begin
            pass <= 1'b1;
            if (range_err || raw_bad) begin
              use_def <= 1'b1;
              err     <= ERR_RANGE;
            end
          end
        end
      end
      S_CLAMP: off  <= (hi_clamp >= cfg.clip_min) ? hi_clamp - cfg.clip_min : '0;
      S_MUL:   prod <= PROD_W'(off) * PROD_W'(cfg.scale_mul);
      S_EMIT:  if (out_free) ch <= ch + 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      channel_index <= ch;
      last_of_frame <= (ch == LAST_CH);
      error_code    <= err;
      if (use_def) begin
        channel_value   <= cfg.failsafe_analog;
        digital_17      <= cfg.failsafe_digital;
        digital_18      <= cfg.failsafe_digital;
        frame_lost      <= 1'b1;
        failsafe_active <= 1'b1;
      end else begin
        channel_value   <= (cfg.scale_div == '0) ? '1 : quotient[VAL_W-1:0];
        digital_17      <= flag_bits[0];
        digital_18      <= flag_bits[1];
        frame_lost      <= flag_bits[2];
        failsafe_active <= flag_bits[3];
      end
    end
  end

endmodule

[hdl/sbus_frame_decoder.sv]
// Serial frame decoder: one byte accepted per cycle while collecting; after the
// 25th byte the input stalls for the decode. The header is read, then every
// channel gets a window check, then each channel is scaled in turn with three
// store reads and the bit-serial divider, and its word is emitted. Failsafe
// frames: 16 results back to back unless the output stalls. Reset (synchronous)
// restores register defaults and empties the frame; the byte store is not cleared.
`include "sbus_frame_decoder_macros.svh"

module sbus_frame_decoder
  import sbus_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [VAL_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              rx_byte,
  input  logic                    frame_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         channel_index,
  output logic [VAL_W-1:0]        channel_value,
  output logic                    digital_17,
  output logic                    digital_18,
  output logic                    frame_lost,
  output logic                    failsafe_active,
  output logic [1:0]              error_code,
  output logic                    last_of_frame
);

  cfg_t              cfg;
  logic [ADDR_W-1:0] byte_count, byte_count_next;
  logic              in_frame, in_frame_next;
  logic              busy;
  logic              in_acc;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] count_inc;
  logic              frame_done;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sanity_min       <= 11'd0;
      cfg.sanity_max       <= 11'd2047;
      cfg.clip_min         <= 11'd172;
      cfg.clip_max         <= 11'd1811;
      cfg.scale_mul        <= 16'd1000;
      cfg.scale_div        <= 16'd1639;
      cfg.failsafe_analog  <= 16'd0;
      cfg.failsafe_digital <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SANITY_MIN: cfg.sanity_min       <= cfg_data[CHANNEL_BITS-1:0];
        CFG_SANITY_MAX: cfg.sanity_max       <= cfg_data[CHANNEL_BITS-1:0];
        CFG_CLIP_MIN:   cfg.clip_min         <= cfg_data[CHANNEL_BITS-1:0];
        CFG_CLIP_MAX:   cfg.clip_max         <= cfg_data[CHANNEL_BITS-1:0];
        CFG_SCALE_MUL:  cfg.scale_mul        <= cfg_data;
        CFG_SCALE_DIV:  cfg.scale_div        <= cfg_data;
        CFG_FS_ANALOG:  cfg.failsafe_analog  <= cfg_data;
        CFG_FS_DIGITAL: cfg.failsafe_digital <= cfg_data[0];
      endcase
    end
  end

  // byte collection; a start word always restarts at byte 0
  always_comb begin
    in_stall   = busy;
    in_acc     = in_valid && !in_stall;
    wr_en      = in_acc && (frame_start || in_frame);
    wr_addr    = frame_start ? START_ADDR : byte_count;
    count_inc  = wr_addr + ADDR_W'(1);
    frame_done = wr_en && (count_inc == LAST_COUNT);
    byte_count_next = byte_count;
    in_frame_next   = in_frame;
    if (wr_en) begin
      byte_count_next = frame_done ? '0 : count_inc;
      in_frame_next   = !frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      in_frame   <= 1'b0;
    end else begin
      byte_count <= byte_count_next;
      in_frame   <= in_frame_next;
    end
  end

  sbus_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbus_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .go              (frame_done),
    .busy            (busy),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_17      (digital_17),
    .digital_18      (digital_18),
    .frame_lost      (frame_lost),
    .failsafe_active (failsafe_active),
    .error_code      (error_code),
    .last_of_frame   (last_of_frame)
  );

  `SBUS_ASSERT_NEXT(a_done_stalls, frame_done, in_stall,
                    "input not stalled after frame end")
  `SBUS_ASSERT_NOW(a_idle_count, !in_frame, byte_count == '0,
                   "byte count left over outside frame")
  `SBUS_ASSERT_NOW(a_last_index, out_valid && last_of_frame, channel_index == LAST_CH,
                   "last word has wrong index")
  `SBUS_ASSERT_NOW(a_err_forces, out_valid && error_code != ERR_NONE,
                   failsafe_active && frame_lost, "error word without failsafe flags")

endmodule
